FILE: rtl/lzw_byte_stream_encoder_macros.svh
// assertion helpers shared by the checker
`ifndef LZW_BYTE_STREAM_ENCODER_MACROS_SVH
`define LZW_BYTE_STREAM_ENCODER_MACROS_SVH

// property checked only outside reset
`define LBSE_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("lbse assertion failed");

// property that also covers the reset cycles
`define LBSE_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("lbse assertion failed");

`endif

FILE: rtl/lbse_pkg.sv
package lbse_pkg;

  // default sizes
  localparam int CODE_BITS_DEF  = 13;
  localparam int HASH_SLOTS_DEF = 16384;

  // configuration
  localparam logic [3:0] MAX_LEN_RESET = 4'd12;
  localparam logic       REG_MAX_LEN   = 1'b0;  // register index, paddr[2]

  // first code that the dictionary hands out
  localparam int FIRST_CODE = 256;

  // one queued input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

endpackage

FILE: rtl/lzw_byte_stream_encoder.sv
// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | data_byte, last_byte
// output   | out_valid | out_stall | out_byte, run_last, stream_end
// a byte goes through the back part in the states take, read, check and done
// when the first probe hits, one more read and check per extra probe; a code
// being packed is emitted one output byte at a time, then its leftover bits
// are kept, and a final flush pads them; a stalled output holds the back part
// after reset and after every last byte a clearing pass over all HASH_SLOTS
// slots runs before the next byte is taken; the input queue holds two bytes
module lzw_byte_stream_encoder #(
  parameter int CODE_BITS  = lbse_pkg::CODE_BITS_DEF,
  parameter int HASH_SLOTS = lbse_pkg::HASH_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        stream_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]      max_len;
  lbse_pkg::item_t in_item;
  lbse_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lbse_pkg::REG_MAX_LEN) ? {28'd0, max_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lbse_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == lbse_pkg::REG_MAX_LEN) begin
      max_len <= pwdata[3:0];
    end
  end

  // front: input queue
  assign in_item.data_byte = data_byte;
  assign in_item.last_byte = last_byte;

  lbse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: dictionary and packer
  lbse_core #(
    .CODE_BITS  (CODE_BITS),
    .HASH_SLOTS (HASH_SLOTS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .max_len    (max_len),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

endmodule

FILE: rtl/lbse_queue.sv
module lbse_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lbse_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output lbse_pkg::item_t q_item
);

  lbse_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // handshake decode
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  // two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= in_item;
        wr_ptr        <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/lbse_core.sv
module lbse_core #(
  parameter int CODE_BITS  = lbse_pkg::CODE_BITS_DEF,
  parameter int HASH_SLOTS = lbse_pkg::HASH_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [3:0]      max_len,
  input  logic            q_valid,
  output logic            q_pop,
  input  lbse_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            stream_end
);

  localparam int HB  = $clog2(HASH_SLOTS);
  localparam int KW  = CODE_BITS + 8;
  localparam int EW  = 1 + KW + CODE_BITS;
  localparam int NFW = CODE_BITS + 1;
  localparam int SHW = 7 + CODE_BITS;
  localparam logic [HB-1:0]  LAST_SLOT = HB'(HASH_SLOTS - 1);
  localparam logic [NFW-1:0] NF_RESET  = NFW'(lbse_pkg::FIRST_CODE);
  localparam logic [4:0]     CB5       = 5'(CODE_BITS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_EMIT, S_FLUSH, S_DONE
  } state_t;

  state_t state;

  // dictionary: {valid, key, code}, slot count a power of two
  logic [EW-1:0] mem [HASH_SLOTS];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [HB-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic [HB-1:0]        clr_addr;
  logic [HB-1:0]        addr;
  logic [HB-1:0]        probes;
  logic [KW-1:0]        key;
  logic [7:0]           cur_byte;
  logic                 cur_last;
  logic [CODE_BITS-1:0] prefix;
  logic [3:0]           plen;
  logic                 have;
  logic [NFW-1:0]       nfree;
  logic [6:0]           acc;
  logic [2:0]           accbits;
  logic [SHW-1:0]       sh;
  logic [4:0]           nb;
  logic                 phase_final;
  logic [7:0]           pend;
  logic                 pend_v;

  logic                 out_free;
  logic                 out_load;
  logic [KW-1:0]        key_w;
  logic [SHW-1:0]       sh_shift;
  logic [7:0]           emit_byte;
  logic [6:0]           acc_m;
  logic [7:0]           flush_byte;
  logic                 slot_valid;
  logic [KW-1:0]        slot_key;
  logic [CODE_BITS-1:0] slot_code;

  // derived values
  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE);
  assign key_w      = {prefix, q_item.data_byte};
  assign sh_shift   = sh >> (nb - 5'd8);
  assign emit_byte  = sh_shift[7:0];
  assign flush_byte = 8'({1'b0, acc} << (4'd8 - {1'b0, accbits}));
  assign slot_valid = rd_q[EW-1];
  assign slot_key   = rd_q[EW-2 -: KW];
  assign slot_code  = rd_q[CODE_BITS-1:0];

  // output register load from the pending byte
  assign out_load = pend_v && out_free &&
                    ((state == S_EMIT && nb >= 5'd8) ||
                     (state == S_FLUSH && accbits != 3'd0) ||
                     (state == S_DONE));

  // leftover bits after the last whole byte
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      acc_m[i] = sh[i] && (5'(i) < nb);
    end
  end

  // memory write port: clearing sweep or new entry
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = {1'b1, key, nfree[CODE_BITS-1:0]};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_CHECK && !slot_valid && !nfree[CODE_BITS]) begin
      mem_we = 1'b1;
    end
  end

  // dictionary memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[addr];
  end

  // sequencer, packer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      have      <= 1'b0;
      prefix    <= '0;
      plen      <= 4'd0;
      nfree     <= NF_RESET;
      acc       <= 7'd0;
      accbits   <= 3'd0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur_byte <= q_item.data_byte;
            cur_last <= q_item.last_byte;
            if (!have) begin
              prefix <= CODE_BITS'(q_item.data_byte);
              plen   <= 4'd1;
              have   <= 1'b1;
              if (q_item.last_byte) begin
                sh          <= {acc, CODE_BITS'(q_item.data_byte)};
                nb          <= 5'(accbits) + CB5;
                phase_final <= 1'b1;
                state       <= S_EMIT;
              end else begin
                state <= S_DONE;
              end
            end else if (plen < max_len) begin
              key    <= key_w;
              addr   <= key_w[HB-1:0];
              probes <= '0;
              state  <= S_READ;
            end else begin
              sh          <= {acc, prefix};
              nb          <= 5'(accbits) + CB5;
              phase_final <= 1'b0;
              state       <= S_EMIT;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!slot_valid) begin
            if (!nfree[CODE_BITS]) begin
              nfree <= nfree + 1'b1;
            end
            sh          <= {acc, prefix};
            nb          <= 5'(accbits) + CB5;
            phase_final <= 1'b0;
            state       <= S_EMIT;
          end else if (slot_key == key) begin
            prefix <= slot_code;
            plen   <= plen + 4'd1;
            if (cur_last) begin
              sh          <= {acc, slot_code};
              nb          <= 5'(accbits) + CB5;
              phase_final <= 1'b1;
              state       <= S_EMIT;
            end else begin
              state <= S_DONE;
            end
          end else if (probes == LAST_SLOT) begin
            // every slot taken by other keys
            sh          <= {acc, prefix};
            nb          <= 5'(accbits) + CB5;
            phase_final <= 1'b0;
            state       <= S_EMIT;
          end else begin
            addr   <= addr + 1'b1;
            probes <= probes + 1'b1;
            state  <= S_READ;
          end
        end
        S_EMIT: begin
          if (nb >= 5'd8) begin
            if (!pend_v || out_free) begin
              if (pend_v) begin
                out_byte   <= pend;
                run_last   <= 1'b0;
                stream_end <= 1'b0;
              end
              pend   <= emit_byte;
              pend_v <= 1'b1;
              nb     <= nb - 5'd8;
            end
          end else begin
            acc     <= acc_m;
            accbits <= nb[2:0];
            if (phase_final) begin
              state <= S_FLUSH;
            end else begin
              prefix <= CODE_BITS'(cur_byte);
              plen   <= 4'd1;
              if (cur_last) begin
                sh          <= {acc_m, CODE_BITS'(cur_byte)};
                nb          <= nb + CB5;
                phase_final <= 1'b1;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_FLUSH: begin
          if (accbits == 3'd0) begin
            state <= S_DONE;
          end else if (!pend_v || out_free) begin
            if (pend_v) begin
              out_byte   <= pend;
              run_last   <= 1'b0;
              stream_end <= 1'b0;
            end
            pend    <= flush_byte;
            pend_v  <= 1'b1;
            acc     <= 7'd0;
            accbits <= 3'd0;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              out_byte   <= pend;
              run_last   <= 1'b1;
              stream_end <= cur_last;
            end
            pend_v <= 1'b0;
            if (cur_last) begin
              have     <= 1'b0;
              prefix   <= '0;
              plen     <= 4'd0;
              nfree    <= NF_RESET;
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lbse_checker.sv
`include "lzw_byte_stream_encoder_macros.svh"

module lbse_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_end
);

  // output register held while stalled
  `LBSE_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)
  `LBSE_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(out_byte))

  // end of stream closes the transaction group
  `LBSE_ASSERT(a_end_is_last, clk, rst, out_valid && stream_end |-> run_last)

  // nothing leaves right after reset
  `LBSE_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid)

endmodule

bind lzw_byte_stream_encoder lbse_checker u_lbse_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .run_last   (run_last),
  .stream_end (stream_end)
);

FILE: sim/lzw_byte_stream_encoder_tb.sv
module lzw_byte_stream_encoder_tb;

  localparam int CBITS = lbse_pkg::CODE_BITS_DEF;
  localparam int NSLOT = lbse_pkg::HASH_SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 3 * NSLOT + 2000;
  localparam logic [2:0] ADDR_MAX_LEN = {lbse_pkg::REG_MAX_LEN, 2'b00};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = '0;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic run_last;
  logic stream_end;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lzw_byte_stream_encoder i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .run_last(run_last), .stream_end(stream_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder mirror state
  bit        dict_valid [NSLOT];
  bit [20:0] dict_key [NSLOT];
  bit [15:0] dict_code [NSLOT];
  bit [15:0] free_code;
  bit [15:0] cur_prefix;
  int        cur_len;
  bit        prefix_open;
  bit [31:0] acc_bits;
  int        acc_count;
  int        max_len;

  lbse_pkg::item_t pending_bytes[$];
  packed_byte_t    expected_bytes[$];
  packed_byte_t    step_bytes[$];

  int  mismatch_count = 0;
  bit  failed = 0;
  bit  quiet_out = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;

  task automatic clear_dict();
    for (int i = 0; i < NSLOT; i++) dict_valid[i] = 0;
    free_code = 16'(lbse_pkg::FIRST_CODE);
  endtask

  task automatic pack_code(input bit [15:0] code);
    bit [31:0] v;
    int n;
    v = (acc_bits << CBITS) | (code & ((1 << CBITS) - 1));
    n = acc_count + CBITS;
    while (n >= 8) begin
      step_bytes.push_back('{v[n-1 -: 8], 1'b0, 1'b0});
      n -= 8;
    end
    acc_bits = v & ((32'd1 << n) - 1);
    acc_count = n;
  endtask

  // predict packed bytes caused by one input byte
  task automatic encode_byte(input lbse_pkg::item_t it);
    bit [20:0] key;
    int idx;
    int slot;
    bit found;
    bit grown;
    bit [7:0] pad;
    step_bytes.delete();
    if (!prefix_open) begin
      cur_prefix = 16'(it.data_byte);
      cur_len = 1;
      prefix_open = 1;
    end else begin
      grown = 0;
      if (cur_len < max_len) begin
        key = {cur_prefix[12:0], it.data_byte};
        idx = key % NSLOT;
        slot = -1;
        found = 0;
        for (int n = 0; n < NSLOT; n++) begin
          if (!dict_valid[idx]) begin
            slot = idx;
            break;
          end
          if (dict_key[idx] == key) begin
            slot = idx;
            found = 1;
            break;
          end
          idx = (idx + 1) % NSLOT;
        end
        if (found) begin
          cur_prefix = dict_code[slot];
          cur_len++;
          grown = 1;
        end else if (slot >= 0 && free_code < (1 << CBITS)) begin
          dict_valid[slot] = 1;
          dict_key[slot] = key;
          dict_code[slot] = free_code;
          free_code++;
        end
      end
      if (!grown) begin
        pack_code(cur_prefix);
        cur_prefix = 16'(it.data_byte);
        cur_len = 1;
      end
    end
    if (it.last_byte) begin
      pack_code(cur_prefix);
      if (acc_count > 0) begin
        pad = 8'(acc_bits << (8 - acc_count));
        step_bytes.push_back('{pad, 1'b0, 1'b0});
      end
      acc_bits = 0;
      acc_count = 0;
      clear_dict();
      cur_prefix = 0;
      cur_len = 0;
      prefix_open = 0;
    end
    for (int k = 0; k < step_bytes.size(); k++) begin
      if (k == step_bytes.size() - 1) begin
        step_bytes[k].run_last = 1'b1;
        step_bytes[k].stream_end = it.last_byte;
      end
      expected_bytes.push_back(step_bytes[k]);
    end
  endtask

  // input driver with random gap bursts
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        encode_byte(pending_bytes.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        if (!quiet_out && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          data_byte <= pending_bytes[0].data_byte;
          last_byte <= pending_bytes[0].last_byte;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor and stall bursts
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          failed = 1;
          if (mismatch_count < 10)
            $display("unexpected output transaction: byte %h", out_byte);
          mismatch_count++;
        end else begin
          packed_byte_t e;
          e = expected_bytes.pop_front();
          if (e.out_byte !== out_byte || e.run_last !== run_last ||
              e.stream_end !== stream_end) begin
            failed = 1;
            if (mismatch_count < 10)
              $display("mismatch: exp byte %h run_last %b end %b, got %h %b %b",
                       e.out_byte, e.run_last, e.stream_end,
                       out_byte, run_last, stream_end);
            mismatch_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_out && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else if (!stim_done || expected_bytes.size() > 0 || pending_bytes.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("lzw_byte_stream_encoder test failed");
        $finish;
      end
    end
  end

  task automatic write_max_len(input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_LEN;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    max_len = value & 4'hf;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid || expected_bytes.size() > 0)
      @(posedge clk);
    // partial codes leave work with no output, and a clear pass may run
    repeat (NSLOT + 50) @(posedge clk);
  endtask

  task automatic add_byte(input bit [7:0] b, input bit last);
    lbse_pkg::item_t it;
    it.data_byte = b;
    it.last_byte = last;
    pending_bytes.push_back(it);
  endtask

  // one stream from a small alphabet so that prefixes repeat
  task automatic add_stream(input int len, input int alphabet);
    bit [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_byte(8'($urandom_range(0, 255)), i == len - 1);
      else
        add_byte(base ^ 8'($urandom_range(0, alphabet - 1)), i == len - 1);
    end
  endtask

  initial begin
    int lens[5];
    lens = '{12, 15, 3, 7, 2};
    max_len = lbse_pkg::MAX_LEN_RESET;
    cur_prefix = 0;
    cur_len = 0;
    prefix_open = 0;
    acc_bits = 0;
    acc_count = 0;
    clear_dict();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: single byte streams at the extremes, repeats, length cap
    write_max_len(2);
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b1);
    for (int i = 0; i < 8; i++) add_byte(8'haa, 1'b0);
    add_byte(8'h55, 1'b1);
    wait_drained();
    write_max_len(0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h01, 1'b1);
    wait_drained();
    write_max_len(1);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b1);
    wait_drained();

    // random phases over several length settings
    foreach (lens[p]) begin
      write_max_len(lens[p]);
      if (p == 4) quiet_out = 1;
      for (int s = 0; s < 4; s++) begin
        add_stream($urandom_range(1, 20), $urandom_range(1, 4));
      end
      wait_drained();
    end
    stim_done = 1;
    if (!failed && expected_bytes.size() == 0) begin
      $display("lzw_byte_stream_encoder test passed");
    end else begin
      $display("lzw_byte_stream_encoder test failed");
    end
    $finish;
  end

endmodule
